/* rtl/core/tcw_pkg.sv */
// tcw_pkg: shared types and constants for the text console writer.
// Holds the command codes, the controller state type and the blank-cell values.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_WRITE_AT   = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_READ_CELL  = 2'd3
    } tcw_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_READ
    } tcw_state_t;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] BLANK_COLOR  = 8'h07;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

endpackage

/* rtl/core/tcw_ram.sv */
// tcw_ram: generic single-port synchronous RAM with a registered read.
// One access per cycle; a write cycle also registers the old word at addr.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/text_console_writer.sv */
// text_console_writer: text-mode console, cell store plus linear cursor.
// Uses tcw_pkg (commands, states, blank values) and tcw_ram (cell store).
//
// Usage
//   A transaction is taken at a rising edge with start high and busy low.
//   The fields command, row, col, char_code and color_attr are sampled there.
//   Every transaction gives exactly one result, shown for one cycle with done
//   high: read_char, read_color, cursor_row, cursor_col, scrolled, ignored.
//   The receiver cannot hold results off; it must take each one as it comes.
//   busy drops in the cycle where done is high, so a new start can go in then.
// Sequencing
//   Put-char, write-at and set-cursor finish from the execute state.
//   Read-cell in range adds a read state for the RAM's registered
//   read; an out-of-range read finishes from the execute state.
//   Scrolling is done with a rotating row base and per-row blank flags, so a
//   scroll itself costs nothing. The first write into a row that is flagged
//   blank (every row after reset, the bottom row after a scroll) first sweeps
//   that row with blanks, one cell a cycle, then executes again.
//   Steady text output is paced by the execute/idle turn plus the row sweep;
//   a new character is taken only once the last one is done.
// Reset
//   rst_n clears the cursor, the row base and sets every row's blank flag, so
//   the whole screen reads as spaces of colour 0x07 with no clearing pass.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [4:0] row,
    input  logic [6:0] col,
    input  logic [7:0] char_code,
    input  logic [7:0] color_attr,
    output logic       done,
    output logic [7:0] read_char,
    output logic [7:0] read_color,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col,
    output logic       scrolled,
    output logic       ignored
);

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);
    localparam logic [RW:0]   ROW_WRAP = (RW + 1)'(SCREEN_ROWS);

    // Controller state
    tcw_pkg::tcw_state_t state_reg, state_next;

    // Latched transaction
    tcw_pkg::tcw_cmd_t cmd_reg, cmd_next;
    logic [7:0]    char_reg, char_next;
    logic [7:0]    color_reg, color_next;
    logic          in_range_reg, in_range_next;
    logic [RW-1:0] tgt_row_reg, tgt_row_next;
    logic [CW-1:0] tgt_col_reg, tgt_col_next;

    // Console state outside the RAM
    logic [RW-1:0]          cur_row_reg, cur_row_next;
    logic [CW-1:0]          cur_col_reg, cur_col_next;
    logic [RW-1:0]          base_reg, base_next;
    logic [SCREEN_ROWS-1:0] blank_reg, blank_next;
    logic [CW-1:0]          clr_col_reg, clr_col_next;

    // Result
    logic       done_reg, done_next;
    logic [7:0] res_char_reg, res_char_next;
    logic [7:0] res_color_reg, res_color_next;
    logic       scrolled_reg, scrolled_next;
    logic       ignored_reg, ignored_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;

    // Address path: logical row -> physical row -> row base address
    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;
    logic [AW-1:0] row_addr;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] clr_addr;

    // Decode of the latched transaction
    logic is_newline;
    logic need_write;
    logic row_blank;
    logic read_hit;
    logic in_range_in;
    logic at_last_cell;

    logic [RW+4:0] row_ext;
    logic [CW+6:0] col_ext;
    logic [RW+4:0] cur_row_ext;
    logic [CW+6:0] cur_col_ext;

    assign row_sum   = {1'b0, tgt_row_reg} + {1'b0, base_reg};
    assign phys_row  = (row_sum >= ROW_WRAP) ? RW'(row_sum - ROW_WRAP) : row_sum[RW-1:0];
    assign row_addr  = AW'(phys_row) * AW'(SCREEN_COLS);
    assign cell_addr = row_addr + AW'(tgt_col_reg);
    assign clr_addr  = row_addr + AW'(clr_col_reg);

    assign is_newline   = (cmd_reg == tcw_pkg::CMD_PUT_CHAR) && (char_reg == tcw_pkg::NEWLINE_CHAR);
    assign need_write   = ((cmd_reg == tcw_pkg::CMD_PUT_CHAR) && !is_newline)
                       || ((cmd_reg == tcw_pkg::CMD_WRITE_AT) && in_range_reg);
    assign row_blank    = blank_reg[phys_row];
    assign read_hit     = (cmd_reg == tcw_pkg::CMD_READ_CELL) && in_range_reg;
    assign at_last_cell = (cur_row_reg == ROW_LAST) && (cur_col_reg == COL_LAST);

    assign in_range_in = (32'(row) < SCREEN_ROWS) && (32'(col) < SCREEN_COLS);
    assign row_ext     = {{RW{1'b0}}, row};
    assign col_ext     = {{CW{1'b0}}, col};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                priority if (need_write && row_blank)
                begin
                    state_next = tcw_pkg::ST_CLEAR;
                end
                else if (read_hit)
                begin
                    state_next = tcw_pkg::ST_READ;
                end
                else
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                if (clr_col_reg == COL_LAST)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        color_next     = color_reg;
        in_range_next  = in_range_reg;
        tgt_row_next   = tgt_row_reg;
        tgt_col_next   = tgt_col_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        base_next      = base_reg;
        blank_next     = blank_reg;
        clr_col_next   = clr_col_reg;
        done_next      = 1'b0;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        scrolled_next  = scrolled_reg;
        ignored_next   = ignored_reg;
        ram_we         = 1'b0;
        ram_addr       = cell_addr;
        ram_wdata      = {color_reg, char_reg};

        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = tcw_pkg::tcw_cmd_t'(command);
                    char_next     = char_code;
                    color_next    = color_attr;
                    in_range_next = in_range_in;
                    if (tcw_pkg::tcw_cmd_t'(command) == tcw_pkg::CMD_PUT_CHAR)
                    begin
                        tgt_row_next = cur_row_reg;
                        tgt_col_next = cur_col_reg;
                    end
                    else
                    begin
                        tgt_row_next = row_ext[RW-1:0];
                        tgt_col_next = col_ext[CW-1:0];
                    end
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                res_char_next  = 8'h00;
                res_color_next = 8'h00;
                scrolled_next  = 1'b0;
                ignored_next   = 1'b0;
                unique case (cmd_reg)
                    tcw_pkg::CMD_PUT_CHAR:
                    begin
                        if (is_newline)
                        begin
                            done_next    = 1'b1;
                            cur_col_next = '0;
                            if (cur_row_reg == ROW_LAST)
                            begin
                                // scroll: old top row becomes the blank bottom row
                                scrolled_next        = 1'b1;
                                blank_next[base_reg] = 1'b1;
                                base_next = (base_reg == ROW_LAST) ? '0 : base_reg + 1'b1;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                        else if (!row_blank)
                        begin
                            ram_we    = 1'b1;
                            done_next = 1'b1;
                            if (at_last_cell)
                            begin
                                scrolled_next        = 1'b1;
                                blank_next[base_reg] = 1'b1;
                                base_next = (base_reg == ROW_LAST) ? '0 : base_reg + 1'b1;
                                cur_col_next         = '0;
                            end
                            else if (cur_col_reg == COL_LAST)
                            begin
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                    end
                    tcw_pkg::CMD_WRITE_AT:
                    begin
                        if (!in_range_reg)
                        begin
                            done_next    = 1'b1;
                            ignored_next = 1'b1;
                        end
                        else if (!row_blank)
                        begin
                            ram_we    = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    tcw_pkg::CMD_SET_CURSOR:
                    begin
                        done_next    = 1'b1;
                        ignored_next = !in_range_reg;
                        if (in_range_reg)
                        begin
                            cur_row_next = tgt_row_reg;
                            cur_col_next = tgt_col_reg;
                        end
                    end
                    tcw_pkg::CMD_READ_CELL:
                    begin
                        // in range: the RAM reads cell_addr this cycle
                        if (!in_range_reg)
                        begin
                            done_next    = 1'b1;
                            ignored_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            tcw_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr;
                ram_wdata = {tcw_pkg::BLANK_COLOR, tcw_pkg::BLANK_CHAR};
                if (clr_col_reg == COL_LAST)
                begin
                    clr_col_next         = '0;
                    blank_next[phys_row] = 1'b0;
                end
                else
                begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end
            tcw_pkg::ST_READ:
            begin
                done_next = 1'b1;
                if (row_blank)
                begin
                    res_char_next  = tcw_pkg::BLANK_CHAR;
                    res_color_next = tcw_pkg::BLANK_COLOR;
                end
                else
                begin
                    res_char_next  = ram_rdata[7:0];
                    res_color_next = ram_rdata[15:8];
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcw_pkg::ST_IDLE;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            base_reg     <= '0;
            blank_reg    <= '1;
            clr_col_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            base_reg     <= base_next;
            blank_reg    <= blank_next;
            clr_col_reg  <= clr_col_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        char_reg      <= char_next;
        color_reg     <= color_next;
        in_range_reg  <= in_range_next;
        tgt_row_reg   <= tgt_row_next;
        tgt_col_reg   <= tgt_col_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        scrolled_reg  <= scrolled_next;
        ignored_reg   <= ignored_next;
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cur_row_ext = {5'b0, cur_row_reg};
    assign cur_col_ext = {7'b0, cur_col_reg};

    assign busy       = (state_reg != tcw_pkg::ST_IDLE);
    assign done       = done_reg;
    assign read_char  = res_char_reg;
    assign read_color = res_color_reg;
    assign cursor_row = cur_row_ext[4:0];
    assign cursor_col = cur_col_ext[6:0];
    assign scrolled   = scrolled_reg;
    assign ignored    = ignored_reg;

    // Checks
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == tcw_pkg::ST_EXEC
                      || $past(state_reg) == tcw_pkg::ST_READ))
        else $error("result strobe without a finishing step");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < SCREEN_ROWS) && (32'(cur_col_reg) < SCREEN_COLS))
        else $error("cursor outside the screen");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) < SCREEN_ROWS)
        else $error("row base outside the screen");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::ST_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == tcw_pkg::ST_EXEC))
        else $error("accepted transaction not executed");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(scrolled_reg && ignored_reg))
        else $error("result both scrolled and ignored");

endmodule

/* dv/tb_text_console_writer.sv */
// tb_text_console_writer: self-checking bench for the text console writer.
// Depends on tcw_pkg and text_console_writer; a shadow console predicts every result.
`timescale 1ns / 1ps

module tb_text_console_writer;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int CELLS       = ROWS * COLS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 950;

    // One result transaction, laid out in port order.
    typedef struct packed {
        logic [7:0] rd_char;
        logic [7:0] rd_color;
        logic [4:0] cur_row;
        logic [6:0] cur_col;
        logic       scrl;
        logic       ign;
    } console_result_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] command;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] char_code;
    logic [7:0] color_attr;
    logic       done;
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
    logic       ignored;

    // Shadow copy of the console: cell store (colour in the high byte) and cursor.
    logic [15:0]     shadow_cells [CELLS];
    int unsigned     shadow_cursor;
    console_result_t pending_results [$];

    int  mismatches  = 0;
    int  live_items  = 0;   // transactions that the block acts on
    int  cycle_count = 0;
    bit  no_idle     = 0;   // set for bursts sent back to back

    text_console_writer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .row        (row),
        .col        (col),
        .char_code  (char_code),
        .color_attr (color_attr),
        .done       (done),
        .read_char  (read_char),
        .read_color (read_color),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .ignored    (ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[text_console_writer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------

    function automatic void clear_shadow();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = {tcw_pkg::BLANK_COLOR, tcw_pkg::BLANK_CHAR};
        shadow_cursor = 0;
    endfunction

    // Move every row up by one, bottom row refilled with blanks.
    function automatic void scroll_shadow();
        for (int i = COLS; i < CELLS; i++)
            shadow_cells[i - COLS] = shadow_cells[i];
        for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
            shadow_cells[i] = {tcw_pkg::BLANK_COLOR, tcw_pkg::BLANK_CHAR};
    endfunction

    // Apply one transaction to the shadow console and return what the block should report.
    function automatic console_result_t console_step(tcw_pkg::tcw_cmd_t cmd, logic [4:0] r,
                                                     logic [6:0] c, logic [7:0] ch,
                                                     logic [7:0] attr);
        console_result_t res;
        int unsigned     target;
        int unsigned     line;
        bit              in_range;
        res      = '0;
        in_range = (r < ROWS) && (c < COLS);
        target   = r * COLS + c;
        if (cmd == tcw_pkg::CMD_PUT_CHAR)
        begin
            if (ch == tcw_pkg::NEWLINE_CHAR)
            begin
                // newline: next row start, or scroll when already on the bottom row
                line = shadow_cursor / COLS;
                if (line == ROWS - 1)
                begin
                    scroll_shadow();
                    res.scrl = 1'b1;
                end
                else
                    line++;
                shadow_cursor = line * COLS;
            end
            else
            begin
                shadow_cells[shadow_cursor] = {attr, ch};
                shadow_cursor++;
                if (shadow_cursor == CELLS)
                begin
                    scroll_shadow();
                    res.scrl      = 1'b1;
                    shadow_cursor = (ROWS - 1) * COLS;
                end
            end
        end
        else if (!in_range)
            res.ign = 1'b1;
        else if (cmd == tcw_pkg::CMD_WRITE_AT)
            shadow_cells[target] = {attr, ch};
        else if (cmd == tcw_pkg::CMD_SET_CURSOR)
            shadow_cursor = target;
        else
        begin
            res.rd_char  = shadow_cells[target][7:0];
            res.rd_color = shadow_cells[target][15:8];
        end
        res.cur_row = 5'(shadow_cursor / COLS);
        res.cur_col = 7'(shadow_cursor % COLS);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transaction, fields change on the falling edge
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int v;
        v = $urandom_range(0, 99);
        if (no_idle || v < 50)
            return 0;
        if (v < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_transaction(input tcw_pkg::tcw_cmd_t cmd, input logic [4:0] r,
                                    input logic [6:0] c, input logic [7:0] ch,
                                    input logic [7:0] attr);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        command    = cmd;
        row        = r;
        col        = c;
        char_code  = ch;
        color_attr = attr;
        start      = 1'b1;
        // taken at the first rising edge that sees busy low
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(console_step(cmd, r, c, ch, attr));
        if (cmd == tcw_pkg::CMD_PUT_CHAR || (r < ROWS && c < COLS))
            live_items++;
        // start stays high when the next transaction follows straight on
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done cycle is matched against the oldest prediction
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s at cycle %0d: expected %0d, got %0d",
                         name, cycle_count, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        console_result_t seen;
        console_result_t want;
        if (rst_n && done)
        begin
            seen = {read_char, read_color, cursor_row, cursor_col, scrolled, ignored};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing outstanding at cycle %0d: %h",
                             cycle_count, seen);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_char",  want.rd_char,  seen.rd_char);
                check_field("read_color", want.rd_color, seen.rd_color);
                check_field("cursor_row", want.cur_row,  seen.cur_row);
                check_field("cursor_col", want.cur_col,  seen.cur_col);
                check_field("scrolled",   want.scrl,     seen.scrl);
                check_field("ignored",    want.ign,      seen.ign);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Screen must read as blanks straight out of reset, top-left and bottom-right corners included.
    task automatic test_power_on_contents();
        send_transaction(tcw_pkg::CMD_READ_CELL, 5'd0, 7'd0, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL, 5'd24, 7'd79, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL, 5'd12, 7'd40, 8'hFF, 8'hFF);
    endtask

    // Field extremes and out-of-range row/col for every addressed command.
    task automatic test_bounds();
        send_transaction(tcw_pkg::CMD_WRITE_AT,   5'd24, 7'd79,  8'hFF, 8'hFF);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd24, 7'd79,  8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_WRITE_AT,   5'd0,  7'd0,   8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_WRITE_AT,   5'd5,  7'd5,   tcw_pkg::NEWLINE_CHAR,
                         8'h5A);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd5,  7'd5,   8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_WRITE_AT,   5'd25, 7'd0,   8'h41, 8'h1F);
        send_transaction(tcw_pkg::CMD_WRITE_AT,   5'd0,  7'd80,  8'h41, 8'h1F);
        send_transaction(tcw_pkg::CMD_SET_CURSOR, 5'd31, 7'd127, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd0,  7'd127, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd31, 7'd0,   8'h00, 8'h00);
    endtask

    // Wrap off the last cell, newline on the bottom row, newline mid-screen.
    task automatic test_scroll_rules();
        send_transaction(tcw_pkg::CMD_SET_CURSOR, 5'd24, 7'd79, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_PUT_CHAR,   5'd31, 7'd127, 8'h41, 8'h1E);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd23, 7'd79, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd24, 7'd79, 8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_PUT_CHAR,   5'd0,  7'd0,  tcw_pkg::NEWLINE_CHAR, 8'hFF);
        send_transaction(tcw_pkg::CMD_SET_CURSOR, 5'd3,  7'd5,  8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_PUT_CHAR,   5'd0,  7'd0,  tcw_pkg::NEWLINE_CHAR, 8'h00);
        send_transaction(tcw_pkg::CMD_PUT_CHAR,   5'd0,  7'd0,  8'hFF, 8'h00);
        send_transaction(tcw_pkg::CMD_PUT_CHAR,   5'd0,  7'd0,  8'h00, 8'hFF);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd4,  7'd0,  8'h00, 8'h00);
        send_transaction(tcw_pkg::CMD_READ_CELL,  5'd4,  7'd1,  8'h00, 8'h00);
    endtask

    function automatic logic [4:0] pick_row(input bit near_bottom);
        if ($urandom_range(0, 99) < 8)
            return 5'($urandom_range(ROWS, 31));
        if (near_bottom)
            return 5'($urandom_range(ROWS - 3, ROWS - 1));
        return 5'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [6:0] pick_col();
        int v;
        v = $urandom_range(0, 99);
        if (v < 8)
            return 7'($urandom_range(COLS, 127));
        if (v < 14)
            return 7'(COLS - 1);
        return 7'($urandom_range(0, COLS - 1));
    endfunction

    // Mostly runs of text with random content; cursor moves lean towards the
    // bottom rows so wraps and scrolls are frequent. Reads lean towards the
    // cursor row and the one above, where fresh text lives.
    task automatic test_random_traffic(input int target_items);
        int          first;
        int          v;
        int          run_len;
        logic [7:0]  ch;
        logic [4:0]  r;
        first = live_items;
        while (live_items - first < target_items)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            v = $urandom_range(0, 99);
            if (v < 45)
            begin
                run_len = $urandom_range(1, 40);
                repeat (run_len)
                begin
                    ch = ($urandom_range(0, 99) < 8) ? tcw_pkg::NEWLINE_CHAR : 8'($urandom);
                    send_transaction(tcw_pkg::CMD_PUT_CHAR, 5'($urandom), 7'($urandom), ch,
                                     8'($urandom));
                end
            end
            else if (v < 60)
                send_transaction(tcw_pkg::CMD_SET_CURSOR, pick_row($urandom_range(0, 1)),
                                 pick_col(), 8'($urandom), 8'($urandom));
            else if (v < 75)
                send_transaction(tcw_pkg::CMD_WRITE_AT, pick_row(1'b0), pick_col(),
                                 8'($urandom), 8'($urandom));
            else
            begin
                r = pick_row(1'b0);
                if ($urandom_range(0, 1) == 0 && r < ROWS)
                    r = 5'(shadow_cursor / COLS - (($urandom_range(0, 1) == 1 &&
                           shadow_cursor >= COLS) ? 1 : 0));
                send_transaction(tcw_pkg::CMD_READ_CELL, r, pick_col(), 8'($urandom),
                                 8'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = tcw_pkg::CMD_PUT_CHAR;
        row        = '0;
        col        = '0;
        char_code  = '0;
        color_attr = '0;
        clear_shadow();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_contents();
        test_bounds();
        test_scroll_rules();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk);
        start = 1'b0;
        // drain, then give a late or spurious done time to show itself
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[text_console_writer] OK");
        else
            $display("[text_console_writer] ERROR");
        $finish;
    end

endmodule
